FILE: hw/rtl/qmsm_pkg.sv
// ----------------------------------------------------------------------------
// qmsm_pkg - shared types, constants and arithmetic helpers
// Frame and register types, the per-motor slot table, divide-by-100 helpers
// and the Q15 truncation used by the stick mixer lanes.
// ----------------------------------------------------------------------------
package qmsm_pkg;

	localparam int LANE_STAGES = 13;
	localparam int CHAIN_W     = 11;
	localparam int SUM_W       = 30;
	localparam int ACC_W       = SUM_W - 15;

	localparam logic [6:0] CUT_THROTTLE = 7'd3;
	localparam logic [6:0] STICK_CENTER = 7'd50;
	localparam logic [6:0] DUTY_MIN     = 7'd1;
	localparam logic [6:0] DUTY_MAX     = 7'd98;

	typedef enum logic [1:0] {
		CH_ROLL,
		CH_PITCH,
		CH_YAW
	} ch_t;

	typedef enum logic [2:0] {
		REG_HIGH_THR,
		REG_LOW_THR,
		REG_THROTTLE_GAIN,
		REG_ROLL_GAIN,
		REG_PITCH_GAIN,
		REG_YAW_GAIN,
		REG_PWM_PERIOD,
		REG_DUTY_LIMIT
	} reg_idx_t;

	typedef struct packed {
		logic [6:0]  high_thr;
		logic [6:0]  low_thr;
		logic [15:0] throttle_gain;
		logic [15:0] roll_gain;
		logic [15:0] pitch_gain;
		logic [15:0] yaw_gain;
		logic [15:0] pwm_period;
		logic [15:0] duty_limit;
	} cfg_t;

	typedef struct packed {
		logic [6:0] throttle;
		logic [6:0] roll;
		logic [6:0] pitch;
		logic [6:0] yaw;
	} frame_t;

	typedef struct packed {
		logic [6:0] dev;
		ch_t        ch;
	} slot_t;

	typedef slot_t [2:0] slots_t;

	// Per motor: positive motions first in channel order, then negative ones.
	localparam ch_t SLOT_CH [4][3] = '{
		'{CH_PITCH, CH_YAW,   CH_ROLL},
		'{CH_ROLL,  CH_PITCH, CH_YAW},
		'{CH_ROLL,  CH_PITCH, CH_YAW},
		'{CH_ROLL,  CH_YAW,   CH_PITCH}
	};
	// Bit k set: slot k reacts to the stick above the high threshold.
	localparam logic [2:0] SLOT_POS [4] = '{3'b011, 3'b000, 3'b011, 3'b011};

	function automatic logic [6:0] stick_of(input frame_t f, input ch_t c);
		logic [6:0] s;
		case (c)
			CH_ROLL:  s = f.roll;
			CH_PITCH: s = f.pitch;
			CH_YAW:   s = f.yaw;
			default:  s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [15:0] gain_of(input cfg_t cfg, input ch_t c);
		logic [15:0] g;
		case (c)
			CH_ROLL:  g = cfg.roll_gain;
			CH_PITCH: g = cfg.pitch_gain;
			CH_YAW:   g = cfg.yaw_gain;
			default:  g = '0;
		endcase
		return g;
	endfunction

	// Deduction of one slot: |stick - 50| when its motion is selected, else zero.
	function automatic logic [6:0] slot_dev(input logic [6:0] s, input cfg_t cfg,
		input logic pos);
		logic above;
		logic below;
		logic sel;
		above = s > cfg.high_thr;
		below = s < cfg.low_thr;
		sel   = pos ? above : (!above && below);
		if (!sel)
			return '0;
		return (s >= STICK_CENTER) ? (s - STICK_CENTER) : (STICK_CENTER - s);
	endfunction

	// Stable descending sort of three slots.
	function automatic slots_t sort3(input slots_t s);
		slots_t     r;
		logic [1:0] rk [3];
		rk[0] = 2'(s[1].dev > s[0].dev) + 2'(s[2].dev > s[0].dev);
		rk[1] = 2'(s[0].dev >= s[1].dev) + 2'(s[2].dev > s[1].dev);
		rk[2] = 2'(s[0].dev >= s[2].dev) + 2'(s[1].dev >= s[2].dev);
		r = s;
		for (int i = 0; i < 3; i++)
			r[rk[i]] = s[i];
		return r;
	endfunction

	// floor(x / 100), exact for x < 2^16
	function automatic logic [9:0] div100_u16(input logic [15:0] x);
		logic [33:0] pr;
		pr = {18'd0, x} * 34'd167773;
		return pr[33:24];
	endfunction

	// floor(x / 100), exact for x < 6553600 (quotient fits 16 bits)
	function automatic logic [15:0] div100_u23(input logic [22:0] x);
		logic [46:0] pr;
		pr = {24'd0, x} * 47'd10737419;
		return pr[45:30];
	endfunction

	// Signed divide by 100 truncating toward zero; magnitude stays below 2^16.
	function automatic logic signed [CHAIN_W-1:0] div100s(input logic signed [20:0] v);
		logic [20:0]                mag;
		logic [9:0]                 q;
		logic signed [CHAIN_W-1:0]  r;
		mag = v[20] ? -v : v;
		q   = div100_u16(mag[15:0]);
		r   = $signed({1'b0, q});
		return v[20] ? -r : r;
	endfunction

	// Divide by 32768 truncating toward zero.
	function automatic logic signed [ACC_W-1:0] trunc_q15(input logic signed [SUM_W-1:0] v);
		logic signed [ACC_W-1:0] q;
		q = v[SUM_W-1:15];
		if (v[SUM_W-1] && (v[14:0] != '0))
			q = q + 15'sd1;
		return q;
	endfunction

	function automatic logic [6:0] duty_clamp(input logic signed [ACC_W-1:0] raw);
		if (raw[ACC_W-1] || (raw == '0))
			return DUTY_MIN;
		if (raw[ACC_W-2:0] > {7'd0, DUTY_MAX})
			return DUTY_MAX;
		return raw[6:0];
	endfunction

endpackage

FILE: hw/rtl/qmsm_lane.sv
// ----------------------------------------------------------------------------
// qmsm_lane - mixing pipeline for one motor
// Selects and sorts the deductions, runs the throttle share chain and the
// gain weighting, clamps the duty and scales it into a PWM compare value.
// ----------------------------------------------------------------------------
module qmsm_lane #(
	parameter int MOTOR        = 0,
	parameter int COMPARE_BITS = 16
) (
	input  logic                               clk,
	input  logic [qmsm_pkg::LANE_STAGES-1:0]   adv,
	input  qmsm_pkg::frame_t                   frame,
	input  qmsm_pkg::cfg_t                     cfg,
	output logic [6:0]                         duty,
	output logic [15:0]                        compare
);

	localparam logic [32:0] CMP_LIM = (33'd1 << COMPARE_BITS) - 33'd1;

	// stage 1: select and sort
	qmsm_pkg::slots_t raw_slots;
	qmsm_pkg::slots_t slots_s1, slots_s2, slots_s3, slots_s4, slots_s5;
	logic [6:0]       t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7, t_s8, t_s9;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			raw_slots[k].ch  = qmsm_pkg::SLOT_CH[MOTOR][k];
			raw_slots[k].dev = qmsm_pkg::slot_dev(
				qmsm_pkg::stick_of(frame, qmsm_pkg::SLOT_CH[MOTOR][k]), cfg,
				qmsm_pkg::SLOT_POS[MOTOR][k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			slots_s1 <= qmsm_pkg::sort3(raw_slots);
			t_s1     <= frame.throttle;
		end
	end

	// stage 2: 2*d0*t
	logic [14:0] p0_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			p0_s2    <= {7'd0, slots_s1[0].dev, 1'b0} * {8'd0, t_s1};
			slots_s2 <= slots_s1;
			t_s2     <= t_s1;
		end
	end

	// stage 3: m = 2*d0*t / 100
	logic [9:0] m_div;
	logic [7:0] m_s3, m_s4, m_s5;

	assign m_div = qmsm_pkg::div100_u16({1'b0, p0_s2});

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			m_s3     <= m_div[7:0];
			slots_s3 <= slots_s2;
			t_s3     <= t_s2;
		end
	end

	// stage 4: 2*d1*(t-m) and m*gain0
	logic signed [8:0]  e1;
	logic signed [17:0] p1_s4;
	logic [23:0]        g0m_s4;

	assign e1 = $signed({2'b00, t_s3}) - $signed({1'b0, m_s3});

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			p1_s4    <= $signed({1'b0, slots_s3[1].dev, 1'b0}) * e1;
			g0m_s4   <= {16'd0, m_s3} *
				{8'd0, qmsm_pkg::gain_of(cfg, slots_s3[0].ch)};
			m_s4     <= m_s3;
			slots_s4 <= slots_s3;
			t_s4     <= t_s3;
		end
	end

	// stage 5: n - m and the first deduction (m is never negative)
	logic signed [qmsm_pkg::CHAIN_W-1:0] q1_s5;
	logic signed [qmsm_pkg::ACC_W-1:0]   acc0_s5, acc0_s6;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			q1_s5    <= qmsm_pkg::div100s({{3{p1_s4[17]}}, p1_s4});
			acc0_s5  <= $signed({6'd0, g0m_s4[23:15]});
			m_s5     <= m_s4;
			slots_s5 <= slots_s4;
			t_s5     <= t_s4;
		end
	end

	// stage 6: 2*d2*(t-n) and (n-m)*gain1
	typedef qmsm_pkg::ch_t ch_hold_t;

	logic signed [11:0] n_val;
	logic signed [11:0] e2;
	logic signed [20:0] p2_s6;
	logic signed [27:0] g1q_s6;
	ch_hold_t           ch2_s6, ch2_s7;

	assign n_val = $signed({4'd0, m_s5}) + {q1_s5[qmsm_pkg::CHAIN_W-1], q1_s5};
	assign e2    = $signed({5'd0, t_s5}) - n_val;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			p2_s6   <= $signed({1'b0, slots_s5[2].dev, 1'b0}) * e2;
			g1q_s6  <= q1_s5 * $signed({1'b0, qmsm_pkg::gain_of(cfg, slots_s5[1].ch)});
			acc0_s6 <= acc0_s5;
			ch2_s6  <= slots_s5[2].ch;
			t_s6    <= t_s5;
		end
	end

	// stage 7: p - n and the second deduction
	logic signed [qmsm_pkg::CHAIN_W-1:0] q2_s7;
	logic signed [qmsm_pkg::SUM_W-1:0]   sum1;
	logic signed [qmsm_pkg::ACC_W-1:0]   acc1_s7, acc1_s8;

	assign sum1 = $signed({acc0_s6, 15'd0}) + $signed({{2{g1q_s6[27]}}, g1q_s6});

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			q2_s7   <= qmsm_pkg::div100s(p2_s6);
			acc1_s7 <= qmsm_pkg::trunc_q15(sum1);
			ch2_s7  <= ch2_s6;
			t_s7    <= t_s6;
		end
	end

	// stage 8: (p-n)*gain2 and t*throttle_gain
	logic signed [27:0] g2q_s8;
	logic [22:0]        tt_s8, tt_s9;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			g2q_s8  <= q2_s7 * $signed({1'b0, qmsm_pkg::gain_of(cfg, ch2_s7)});
			tt_s8   <= {16'd0, t_s7} * {7'd0, cfg.throttle_gain};
			acc1_s8 <= acc1_s7;
			t_s8    <= t_s7;
		end
	end

	// stage 9: third deduction
	logic signed [qmsm_pkg::SUM_W-1:0] sum2;
	logic signed [qmsm_pkg::ACC_W-1:0] acc2_s9;

	assign sum2 = $signed({acc1_s8, 15'd0}) + $signed({{2{g2q_s8[27]}}, g2q_s8});

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			acc2_s9 <= qmsm_pkg::trunc_q15(sum2);
			tt_s9   <= tt_s8;
			t_s9    <= t_s8;
		end
	end

	// stage 10: raw duty, throttle cut and clamp
	logic signed [qmsm_pkg::SUM_W-1:0] raw_sum;
	logic signed [qmsm_pkg::ACC_W-1:0] raw_duty;
	logic [6:0]                        duty_s10, duty_s11, duty_s12, duty_s13;

	assign raw_sum  = $signed({7'd0, tt_s9}) - $signed({acc2_s9, 15'd0});
	assign raw_duty = qmsm_pkg::trunc_q15(raw_sum);

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			duty_s10 <= (t_s9 < qmsm_pkg::CUT_THROTTLE) ? qmsm_pkg::DUTY_MIN :
				qmsm_pkg::duty_clamp(raw_duty);
		end
	end

	// stages 11-13: compare = ((duty * period) / 100 * limit) >> 16
	logic [22:0] x_s11;
	logic [15:0] xd_s12;
	logic [31:0] scaled;
	logic [15:0] cmp_s13;

	assign scaled = {16'd0, xd_s12} * {16'd0, cfg.duty_limit};

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			x_s11    <= {16'd0, duty_s10} * {7'd0, cfg.pwm_period};
			duty_s11 <= duty_s10;
		end
		if (adv[11]) begin
			xd_s12   <= qmsm_pkg::div100_u23(x_s11);
			duty_s12 <= duty_s11;
		end
		if (adv[12]) begin
			cmp_s13  <= ({17'd0, scaled[31:16]} > CMP_LIM) ? CMP_LIM[15:0] :
				scaled[31:16];
			duty_s13 <= duty_s12;
		end
	end

	assign duty    = duty_s13;
	assign compare = cmp_s13;

endmodule

FILE: hw/rtl/quad_motor_stick_mixer_core.sv
// ----------------------------------------------------------------------------
// quad_motor_stick_mixer_core - four-motor stick mixer
// done rises as the last lane stage presents an accepted frame's result.
// Throughput: one frame per cycle; busy drops the cycle after reset releases
// and stays low. The 13 stages follow the chain of multiplies in each lane.
// Reset clears all stage valids and loads the register defaults; busy is
// high during reset. Results are one-cycle strobes that are never held off.
// ----------------------------------------------------------------------------
module quad_motor_stick_mixer_core #(
	parameter int COMPARE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// frame channel
	input  logic        start,
	output logic        busy,
	input  logic [6:0]  throttle_pct,
	input  logic [6:0]  roll_pct,
	input  logic [6:0]  pitch_pct,
	input  logic [6:0]  yaw_pct,
	// result channel
	output logic        done,
	output logic [6:0]  motor1_duty,
	output logic [6:0]  motor2_duty,
	output logic [6:0]  motor3_duty,
	output logic [6:0]  motor4_duty,
	output logic [15:0] motor1_compare,
	output logic [15:0] motor2_compare,
	output logic [15:0] motor3_compare,
	output logic [15:0] motor4_compare,
	output logic        throttle_cut,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NS = qmsm_pkg::LANE_STAGES;

	// ---------------- configuration registers ----------------
	qmsm_pkg::cfg_t     cfg_q;
	qmsm_pkg::reg_idx_t reg_idx;
	logic               cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = qmsm_pkg::reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_thr      <= 7'd60;
			cfg_q.low_thr       <= 7'd40;
			cfg_q.throttle_gain <= 16'd32768;
			cfg_q.roll_gain     <= 16'd6554;
			cfg_q.pitch_gain    <= 16'd6554;
			cfg_q.yaw_gain      <= 16'd6554;
			cfg_q.pwm_period    <= 16'd50000;
			cfg_q.duty_limit    <= 16'd13107;
		end else if (cfg_wr) begin
			case (reg_idx)
				qmsm_pkg::REG_HIGH_THR:      cfg_q.high_thr      <= pwdata[6:0];
				qmsm_pkg::REG_LOW_THR:       cfg_q.low_thr       <= pwdata[6:0];
				qmsm_pkg::REG_THROTTLE_GAIN: cfg_q.throttle_gain <= pwdata[15:0];
				qmsm_pkg::REG_ROLL_GAIN:     cfg_q.roll_gain     <= pwdata[15:0];
				qmsm_pkg::REG_PITCH_GAIN:    cfg_q.pitch_gain    <= pwdata[15:0];
				qmsm_pkg::REG_YAW_GAIN:      cfg_q.yaw_gain      <= pwdata[15:0];
				qmsm_pkg::REG_PWM_PERIOD:    cfg_q.pwm_period    <= pwdata[15:0];
				qmsm_pkg::REG_DUTY_LIMIT:    cfg_q.duty_limit    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			qmsm_pkg::REG_HIGH_THR:      prdata = {25'd0, cfg_q.high_thr};
			qmsm_pkg::REG_LOW_THR:       prdata = {25'd0, cfg_q.low_thr};
			qmsm_pkg::REG_THROTTLE_GAIN: prdata = {16'd0, cfg_q.throttle_gain};
			qmsm_pkg::REG_ROLL_GAIN:     prdata = {16'd0, cfg_q.roll_gain};
			qmsm_pkg::REG_PITCH_GAIN:    prdata = {16'd0, cfg_q.pitch_gain};
			qmsm_pkg::REG_YAW_GAIN:      prdata = {16'd0, cfg_q.yaw_gain};
			qmsm_pkg::REG_PWM_PERIOD:    prdata = {16'd0, cfg_q.pwm_period};
			qmsm_pkg::REG_DUTY_LIMIT:    prdata = {16'd0, cfg_q.duty_limit};
			default:                     prdata = '0;
		endcase
	end

	// ---------------- frame transfer and stage valids ----------------
	logic            rdy_q;
	logic            accept;
	logic [NS-1:0]   vld_q;
	logic [NS-1:0]   cut_q;
	logic [NS-1:0]   adv;
	qmsm_pkg::frame_t frame;

	assign busy   = !rdy_q;
	assign accept = start && rdy_q;
	assign adv    = {vld_q[NS-2:0], accept};

	assign frame.throttle = throttle_pct;
	assign frame.roll     = roll_pct;
	assign frame.pitch    = pitch_pct;
	assign frame.yaw      = yaw_pct;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q <= 1'b0;
			vld_q <= '0;
		end else begin
			rdy_q <= 1'b1;
			vld_q <= {vld_q[NS-2:0], accept};
		end
	end

	// cut flag rides alongside the valids; advance every cycle
	always_ff @(posedge clk) begin
		cut_q <= {cut_q[NS-2:0], (throttle_pct < qmsm_pkg::CUT_THROTTLE)};
	end

	// ---------------- motor lanes ----------------
	logic [6:0]  duty_w [4];
	logic [15:0] cmp_w  [4];

	for (genvar mo = 0; mo < 4; mo++) begin : g_lane
		qmsm_lane #(
			.MOTOR        (mo),
			.COMPARE_BITS (COMPARE_BITS)
		) u_lane (
			.clk     (clk),
			.adv     (adv),
			.frame   (frame),
			.cfg     (cfg_q),
			.duty    (duty_w[mo]),
			.compare (cmp_w[mo])
		);
	end

	assign done           = vld_q[NS-1];
	assign throttle_cut   = cut_q[NS-1];
	assign motor1_duty    = duty_w[0];
	assign motor2_duty    = duty_w[1];
	assign motor3_duty    = duty_w[2];
	assign motor4_duty    = duty_w[3];
	assign motor1_compare = cmp_w[0];
	assign motor2_compare = cmp_w[1];
	assign motor3_compare = cmp_w[2];
	assign motor4_compare = cmp_w[3];

	// ---------------- assertions ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##13 done)
		else $error("accepted frame did not produce a result on time");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (motor1_duty >= qmsm_pkg::DUTY_MIN && motor1_duty <= qmsm_pkg::DUTY_MAX &&
			motor2_duty >= qmsm_pkg::DUTY_MIN && motor2_duty <= qmsm_pkg::DUTY_MAX &&
			motor3_duty >= qmsm_pkg::DUTY_MIN && motor3_duty <= qmsm_pkg::DUTY_MAX &&
			motor4_duty >= qmsm_pkg::DUTY_MIN && motor4_duty <= qmsm_pkg::DUTY_MAX))
		else $error("motor duty outside clamp range");

	a_cut_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(done && throttle_cut) |-> (motor1_duty == qmsm_pkg::DUTY_MIN &&
			motor2_duty == qmsm_pkg::DUTY_MIN && motor3_duty == qmsm_pkg::DUTY_MIN &&
			motor4_duty == qmsm_pkg::DUTY_MIN))
		else $error("throttle cut result with nonzero mix");

	a_busy_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy returned after reset");

endmodule
